// ===== hdl/bbr_pkg.sv =====
`default_nettype none
package bbr_pkg;

    localparam int GAIN_FRACTION_BITS_DEF = 8;

    typedef enum logic [1:0] {
        MODE_STARTUP  = 2'd0,
        MODE_DRAIN    = 2'd1,
        MODE_PROBE_BW = 2'd2,
        MODE_PROBE_RTT = 2'd3
    } bbr_mode_t;

    typedef enum logic [1:0] {
        CFG_DEFAULT_BW  = 2'd0,
        CFG_DEFAULT_RTT = 2'd1,
        CFG_PACKET_BYTES = 2'd2,
        CFG_START_MODE  = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SCALE,
        ST_OUT
    } ctrl_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture input transaction, start products
        logic div_start; // start BDP division
        logic scale;     // apply gains and update mode/state
        logic io_event;  // perform plateau detection update
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic is_time;
        logic new_round;
    } dp_status_t;

    localparam logic [31:0] US_PER_S = 32'd1000000;
    localparam logic [31:0] CWND_MIN = 32'd4;
    localparam logic [1:0]  STALL_LIMIT = 2'd3;

endpackage
`default_nettype wire

// ===== hdl/bbr_ctrl.sv =====
`default_nettype none
module bbr_ctrl
    import bbr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire logic       out_fire,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            in_ready,
    output logic            out_valid
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) state_next = ST_MUL;
            end
            ST_MUL: begin
                if (status.is_time && status.new_round) state_next = ST_DIV;
                else state_next = ST_OUT;
            end
            ST_DIV: begin
                if (status.div_done) state_next = ST_SCALE;
            end
            ST_SCALE: state_next = ST_OUT;
            ST_OUT: begin
                if (out_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            ST_MUL: begin
                cmd.div_start = status.is_time && status.new_round;
                cmd.io_event = !status.is_time;
            end
            ST_DIV: ;
            ST_SCALE: cmd.scale = 1'b1;
            ST_OUT: out_valid = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/bbr_dp.sv =====
`default_nettype none
module bbr_dp
    import bbr_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       status,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [23:0] cfg_data,
    input  wire logic        in_func,
    input  wire logic [31:0] in_round,
    input  wire logic [23:0] in_bw,
    input  wire logic [23:0] in_rtt,
    input  wire logic [31:0] in_inflight,
    input  wire logic        in_applim,
    output logic             rates_updated,
    output logic [41:0]      pace_out,
    output logic [29:0]      congestion_window,
    output logic [1:0]       current_mode,
    output logic             plateau_reached
);

    localparam int GW = GAIN_FRACTION_BITS + 2;
    localparam int UNIT = 1 << GAIN_FRACTION_BITS;
    localparam logic [GW-1:0] HIGH_GAIN = GW'(UNIT * 2885 / 1000 + 1);
    localparam logic [GW-1:0] DRAIN_GAIN = GW'(UNIT * 1000 / 2885);
    localparam logic [GW-1:0] CWND_GAIN = GW'(UNIT * 2);
    localparam logic [GW-1:0] UP_GAIN = GW'(UNIT * 5 / 4);
    localparam logic [GW-1:0] DOWN_GAIN = GW'(UNIT * 3 / 4);
    localparam logic [GW-1:0] ONE_GAIN = GW'(UNIT);
    localparam logic [41:0] PACE_MAX = '1;
    localparam logic [29:0] CWND_MAX = '1;
    // ceil(2^48 / 1e6): reciprocal applied to the upper 32 bits of the product.
    localparam logic [28:0] RECIP_US = 29'd281474977;
    localparam logic [19:0] US_PER_S_W = US_PER_S[19:0];

    logic [23:0] dflt_bw_reg, dflt_rtt_reg;
    logic [15:0] pkt_bytes_reg;

    logic [1:0]  mode_reg;
    logic [31:0] last_round_reg;
    logic [23:0] plat_bw_reg;
    logic [31:0] latched_bdp_reg;
    logic        full_reg;
    logic [1:0]  stall_reg;
    logic        nrf_reg;

    logic        func_reg, applim_reg;
    logic [31:0] round_reg, inflight_reg;
    logic [23:0] bwe_reg;
    logic [47:0] prod_reg;   // bw * rtt
    logic [39:0] bytes_reg;  // bw * packet_bytes

    // BDP divide by reciprocal multiplication: an estimate that is off by at
    // most one, then a remainder check that corrects it.
    logic [28:0] q0_reg;
    logic [48:0] rem_reg;
    logic [31:0] quo_reg;
    logic [1:0]  div_step_reg;

    logic [23:0] bw_eff, rtt_eff;
    assign bw_eff  = (in_bw != 24'd0) ? in_bw : dflt_bw_reg;
    assign rtt_eff = (in_rtt != 24'd0) ? in_rtt : dflt_rtt_reg;

    assign status.div_done  = div_step_reg == 2'd3;
    assign status.is_time   = !func_reg;
    assign status.new_round = round_reg != last_round_reg;

    logic [60:0] est_full;
    logic [48:0] back_prod;
    assign est_full = {29'd0, prod_reg[47:16]} * {32'd0, RECIP_US};
    assign back_prod = {20'd0, q0_reg} * {29'd0, US_PER_S_W};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            applim_reg <= in_applim;
            round_reg <= in_round;
            inflight_reg <= in_inflight;
            bwe_reg <= in_bw;
            prod_reg <= {24'd0, bw_eff} * {24'd0, rtt_eff};
            bytes_reg <= {16'd0, bw_eff} * {24'd0, pkt_bytes_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_step_reg <= '0;
        end else if (cmd.div_start) begin
            q0_reg <= est_full[60:32];
            div_step_reg <= 2'd1;
        end else if (div_step_reg == 2'd1) begin
            rem_reg <= {1'b0, prod_reg} - back_prod;
            div_step_reg <= 2'd2;
        end else if (div_step_reg == 2'd2) begin
            if (rem_reg[48]) quo_reg <= {3'd0, q0_reg - 29'd1};
            else if (rem_reg[47:0] >= {28'd0, US_PER_S_W}) quo_reg <= {3'd0, q0_reg + 29'd1};
            else quo_reg <= {3'd0, q0_reg};
            div_step_reg <= 2'd3;
        end
    end

    function automatic logic [GW-1:0] cyc_gain(input logic [2:0] ph);
        case (ph)
            3'd0: cyc_gain = UP_GAIN;
            3'd1: cyc_gain = DOWN_GAIN;
            default: cyc_gain = ONE_GAIN;
        endcase
    endfunction

    // Scale step: mode transitions then gains.
    logic [31:0] bdp;
    logic [1:0]  m1, m2;
    logic [31:0] base;
    logic [GW-1:0] pg, cg;
    logic [39+GW:0] pace_full;
    logic [31+GW:0] cwnd_full;
    logic [39+GW:0] pace_sh;
    logic [31+GW:0] cwnd_sh;
    always_comb begin
        bdp = quo_reg;
        m1 = (mode_reg == MODE_STARTUP && full_reg) ? MODE_DRAIN : mode_reg;
        m2 = m1;
        if (m1 == MODE_DRAIN) begin
            if (inflight_reg <= ((mode_reg == MODE_STARTUP) ? bdp : latched_bdp_reg))
                m2 = MODE_PROBE_BW;
        end
        base = (bdp > CWND_MIN) ? bdp : CWND_MIN;
        case (m2)
            MODE_STARTUP: begin pg = HIGH_GAIN; cg = HIGH_GAIN; end
            MODE_DRAIN:   begin pg = DRAIN_GAIN; cg = HIGH_GAIN; end
            MODE_PROBE_BW: begin pg = cyc_gain(round_reg[2:0]); cg = CWND_GAIN; end
            default:      begin pg = DRAIN_GAIN; cg = CWND_GAIN; end
        endcase
        pace_full = {{GW{1'b0}}, bytes_reg} * {{40{1'b0}}, pg};
        cwnd_full = {{GW{1'b0}}, base} * {{32{1'b0}}, cg};
        pace_sh = pace_full >> GAIN_FRACTION_BITS;
        cwnd_sh = cwnd_full >> GAIN_FRACTION_BITS;
    end

    logic [24+GW:0] thr_full;
    assign thr_full = {{GW+1{1'b0}}, plat_bw_reg} * {25'd0, UP_GAIN};
    logic [24+GW:0] thr;
    assign thr = thr_full >> GAIN_FRACTION_BITS;
    logic [1:0] stall_inc;
    assign stall_inc = stall_reg + 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dflt_bw_reg <= 24'd4096;
            dflt_rtt_reg <= 24'd1000000;
            pkt_bytes_reg <= 16'd1400;
            mode_reg <= MODE_PROBE_BW;
            last_round_reg <= '1;
            plat_bw_reg <= '0;
            latched_bdp_reg <= '0;
            full_reg <= 1'b0;
            stall_reg <= '0;
            nrf_reg <= 1'b0;
            rates_updated <= 1'b0;
            pace_out <= '0;
            congestion_window <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    CFG_DEFAULT_BW:   dflt_bw_reg <= cfg_data;
                    CFG_DEFAULT_RTT:  dflt_rtt_reg <= cfg_data;
                    CFG_PACKET_BYTES: pkt_bytes_reg <= cfg_data[15:0];
                    CFG_START_MODE:   mode_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                rates_updated <= 1'b0;
                pace_out <= '0;
                congestion_window <= '0;
            end
            if (cmd.io_event) begin
                if (!full_reg && nrf_reg && !applim_reg) begin
                    if ({{GW+1{1'b0}}, bwe_reg} >= thr) begin
                        plat_bw_reg <= bwe_reg;
                        stall_reg <= '0;
                    end else begin
                        stall_reg <= stall_inc;
                        full_reg <= stall_inc >= STALL_LIMIT;
                    end
                end
                nrf_reg <= 1'b0;
            end
            if (cmd.scale) begin
                nrf_reg <= 1'b1;
                if (mode_reg == MODE_STARTUP && full_reg) latched_bdp_reg <= bdp;
                mode_reg <= m2;
                last_round_reg <= round_reg;
                rates_updated <= 1'b1;
                pace_out <= (pace_sh > {{GW{1'b0}}, PACE_MAX[39:0]} && pace_sh[39+GW:42] != '0)
                            ? PACE_MAX : pace_sh[41:0];
                congestion_window <= (cwnd_sh[31+GW:30] != '0) ? CWND_MAX : cwnd_sh[29:0];
            end
        end
    end

    assign current_mode = mode_reg;
    assign plateau_reached = full_reg;

endmodule
`default_nettype wire

// ===== hdl/bbr_congestion_mode_control_top.sv =====
// Sequence: after acceptance an I/O event or a repeated round goes straight to the result;
// a new round first passes the products, a three-step reciprocal BDP divide and the gain step.
// Throughput: one transaction at a time; input is ready again in the cycle after the
// result transaction.
// Reset: aresetn is synchronous and active low; it resets the controller state and the
// config, mode state and output registers, sets mode to probe bandwidth, last_round to all ones.
`default_nettype none
module bbr_congestion_mode_control_top
    import bbr_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = GAIN_FRACTION_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [31:0] s_round_count,
    input  wire logic [23:0] s_bandwidth_estimate,
    input  wire logic [23:0] s_min_rtt_us,
    input  wire logic [31:0] s_inflight_packets,
    input  wire logic        s_app_limited,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_rates_updated,
    output logic [41:0]      m_pacing_rate,
    output logic [29:0]      m_congestion_window,
    output logic [1:0]       m_current_mode,
    output logic             m_plateau_reached
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences each transaction; the datapath holds the configuration and mode state.
    bbr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_valid && s_ready),
        .out_fire  (m_valid && m_ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (s_ready),
        .out_valid (m_valid)
    );

    bbr_dp #(.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_idx           (cfg_index),
        .cfg_data          (cfg_data),
        .in_func           (s_func),
        .in_round          (s_round_count),
        .in_bw             (s_bandwidth_estimate),
        .in_rtt            (s_min_rtt_us),
        .in_inflight       (s_inflight_packets),
        .in_applim         (s_app_limited),
        .rates_updated     (m_rates_updated),
        .pace_out          (m_pacing_rate),
        .congestion_window (m_congestion_window),
        .current_mode      (m_current_mode),
        .plateau_reached   (m_plateau_reached)
    );

    // The block never takes a new transaction while a result is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input accepted while result pending");

    // A result is never presented in the cycle after acceptance.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("result too early");

    // Once the plateau is seen it stays seen.
    a_plateau_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_plateau_reached |=> m_plateau_reached) else $error("plateau flag dropped");

endmodule
`default_nettype wire

// ===== tb/bbr_congestion_mode_control_checker.sv =====
`default_nettype none
module bbr_congestion_mode_control_checker
    import bbr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_func,
    input  wire logic [31:0] s_round_count,
    input  wire logic [23:0] s_bandwidth_estimate,
    input  wire logic [23:0] s_min_rtt_us,
    input  wire logic [31:0] s_inflight_packets,
    input  wire logic        s_app_limited,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_rates_updated,
    input  wire logic [41:0] m_pacing_rate,
    input  wire logic [29:0] m_congestion_window,
    input  wire logic [1:0]  m_current_mode,
    input  wire logic        m_plateau_reached,
    output int               fail_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = GAIN_FRACTION_BITS_DEF;
    localparam logic [63:0] UNIT = 64'd1 << FB;
    localparam logic [63:0] HIGH_GAIN = UNIT * 2885 / 1000 + 1;
    localparam logic [63:0] DRAIN_GAIN = UNIT * 1000 / 2885;
    localparam logic [63:0] CWND_GAIN = UNIT * 2;
    localparam logic [63:0] PLATEAU_GAIN = UNIT * 5 / 4;
    localparam logic [63:0] PACE_MAX = (64'd1 << 42) - 1;
    localparam logic [63:0] CWND_MAX = (64'd1 << 30) - 1;

    typedef struct packed {
        logic        updated;
        logic [41:0] pace;
        logic [29:0] cwnd;
        bbr_mode_t   mode;
        logic        plateau;
    } rate_report_t;

    rate_report_t report_q[$];

    logic [23:0] def_bw, def_rtt;
    logic [15:0] pkt_bytes;
    bbr_mode_t   mode;
    logic [31:0] last_round, latched_bdp;
    logic [23:0] plateau_bw;
    logic        full_reached, new_round_flag;
    logic [1:0]  stall_rounds;

    function automatic logic [63:0] bdp_of(logic [23:0] bwe, logic [23:0] rtt);
        logic [63:0] b, r;
        b = (bwe != 0) ? 64'(bwe) : 64'(def_bw);
        r = (rtt != 0) ? 64'(rtt) : 64'(def_rtt);
        return (b * r / 1000000) & 64'hFFFF_FFFF;
    endfunction

    function automatic logic [63:0] apply_gain(logic [63:0] x, logic [63:0] g,
                                               logic [63:0] cap);
        logic [63:0] v;
        v = (x * g) >> FB;
        return (v > cap) ? cap : v;
    endfunction

    task automatic predict_event();
        rate_report_t r;
        logic [63:0] bdp, base, bytes, pg, cg, thr;
        r = '0;
        if (!s_func) begin
            if (s_round_count != last_round) begin
                new_round_flag = 1'b1;
                if (mode == MODE_STARTUP && full_reached) begin
                    mode = MODE_DRAIN;
                    latched_bdp = 32'(bdp_of(s_bandwidth_estimate, s_min_rtt_us));
                end
                if (mode == MODE_DRAIN && s_inflight_packets <= latched_bdp)
                    mode = MODE_PROBE_BW;
                bdp = bdp_of(s_bandwidth_estimate, s_min_rtt_us);
                base = (bdp > 4) ? bdp : 64'd4;
                bytes = ((s_bandwidth_estimate != 0) ? 64'(s_bandwidth_estimate)
                         : 64'(def_bw)) * 64'(pkt_bytes);
                case (mode)
                    MODE_STARTUP: begin pg = HIGH_GAIN; cg = HIGH_GAIN; end
                    MODE_DRAIN: begin pg = DRAIN_GAIN; cg = HIGH_GAIN; end
                    MODE_PROBE_BW: begin
                        case (s_round_count[2:0])
                            3'd0: pg = UNIT * 5 / 4;
                            3'd1: pg = UNIT * 3 / 4;
                            default: pg = UNIT;
                        endcase
                        cg = CWND_GAIN;
                    end
                    default: begin pg = DRAIN_GAIN; cg = CWND_GAIN; end
                endcase
                r.updated = 1'b1;
                r.pace = 42'(apply_gain(bytes, pg, PACE_MAX));
                r.cwnd = 30'(apply_gain(base, cg, CWND_MAX));
                last_round = s_round_count;
            end
        end else begin
            if (!full_reached && new_round_flag && !s_app_limited) begin
                thr = (64'(plateau_bw) * PLATEAU_GAIN) >> FB;
                if (64'(s_bandwidth_estimate) >= thr) begin
                    plateau_bw = s_bandwidth_estimate;
                    stall_rounds = 2'd0;
                end else begin
                    stall_rounds = stall_rounds + 2'd1;
                    full_reached = (stall_rounds >= STALL_LIMIT);
                end
            end
            new_round_flag = 1'b0;
        end
        r.mode = mode;
        r.plateau = full_reached;
        report_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        rate_report_t e;
        if (!aresetn) begin
            def_bw = 24'd4096;
            def_rtt = 24'd1000000;
            pkt_bytes = 16'd1400;
            mode = MODE_PROBE_BW;
            last_round = '1;
            latched_bdp = '0;
            plateau_bw = '0;
            full_reached = 1'b0;
            new_round_flag = 1'b0;
            stall_rounds = '0;
            fail_count = 0;
            pending_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DEFAULT_BW: def_bw = cfg_data;
                    CFG_DEFAULT_RTT: def_rtt = cfg_data;
                    CFG_PACKET_BYTES: pkt_bytes = cfg_data[15:0];
                    CFG_START_MODE: mode = bbr_mode_t'(cfg_data[1:0]);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (report_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction at %0t", $realtime);
                end else begin
                    e = report_q.pop_front();
                    if (e.updated !== m_rates_updated || e.pace !== m_pacing_rate ||
                        e.cwnd !== m_congestion_window || e.mode !== m_current_mode ||
                        e.plateau !== m_plateau_reached) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result differs: exp upd=%0d pace=%0d cwnd=%0d %s",
                                e.updated, e.pace, e.cwnd, "");
                            $display("  exp mode=%0d plat=%0d", e.mode, e.plateau);
                            $display("  got upd=%0d pace=%0d cwnd=%0d mode=%0d plat=%0d",
                                m_rates_updated, m_pacing_rate, m_congestion_window,
                                m_current_mode, m_plateau_reached);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                predict_event();
            pending_count <= report_q.size();
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bbr_pkg::*;

    // Inactivity limit: well above the time a new round takes and the longest
    // sender gap or receiver hold-off.
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_EVENTS = 1750;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = 1'b0;
    logic [31:0] s_round_count = '0;
    logic [23:0] s_bandwidth_estimate = '0;
    logic [23:0] s_min_rtt_us = '0;
    logic [31:0] s_inflight_packets = '0;
    logic        s_app_limited = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_rates_updated;
    logic [41:0] m_pacing_rate;
    logic [29:0] m_congestion_window;
    logic [1:0]  m_current_mode;
    logic        m_plateau_reached;
    int          fail_count, pending_count;

    // The receiver's hold-off is requested by the stimulus process and
    // counted down by the receiver process itself.
    int  hold_request = 0;
    logic [31:0] round_now = 0;

    always #2 aclk = ~aclk;

    bbr_congestion_mode_control_top i_dut (.*);

    bbr_congestion_mode_control_checker i_checker (.*);

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(3);
        if (p < 98) return $urandom_range(20);
        return $urandom_range(150);
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // One event offered and held until the block takes the transaction.
    // Valid is left high at the accepting edge; the next call or
    // drain_results lowers it or replaces the payload in that same step.
    task automatic send_event(logic fn, logic [31:0] rnd, logic [23:0] bwe,
                              logic [23:0] rtt, logic [31:0] infl, logic al);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        s_round_count <= rnd;
        s_bandwidth_estimate <= bwe;
        s_min_rtt_us <= rtt;
        s_inflight_packets <= infl;
        s_app_limited <= al;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Waits until every outstanding result has arrived, plus a margin so
    // a configuration write finds the block idle.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_field24();
        case ($urandom_range(5))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(200));
            default: return 24'($urandom);
        endcase
    endfunction

    // A well-formed round: a new time event, then mostly an I/O event
    // that drives the plateau detection.
    task automatic send_round(logic [23:0] bw_base, logic shrink);
        logic [23:0] bwe;
        logic [31:0] infl;
        round_now = round_now + 1;
        bwe = shrink ? 24'(bw_base - $urandom_range(3)) : 24'($urandom);
        infl = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(5000));
        send_event(1'b0, round_now, bwe, rand_field24(), infl, 1'b0);
        if ($urandom_range(4) != 0)
            send_event(1'b1, $urandom, bwe, 24'($urandom), $urandom,
                       ($urandom_range(7) == 0));
    endtask

    task automatic settle_config(int k);
        case (k % 4)
            0: begin
                write_reg(CFG_DEFAULT_BW, 24'd1);
                write_reg(CFG_DEFAULT_RTT, 24'd1);
                write_reg(CFG_PACKET_BYTES, 24'd64);
            end
            1: begin
                write_reg(CFG_DEFAULT_BW, 24'hFFFFFF);
                write_reg(CFG_DEFAULT_RTT, 24'hFFFFFF);
                write_reg(CFG_PACKET_BYTES, 24'd65535);
            end
            default: begin
                write_reg(CFG_DEFAULT_BW, 24'($urandom_range(1, 24'hFFFFFF)));
                write_reg(CFG_DEFAULT_RTT, 24'($urandom_range(1, 24'hFFFFFF)));
                write_reg(CFG_PACKET_BYTES, 24'($urandom_range(64, 65535)));
            end
        endcase
        // Startup is the mode that exercises the whole progression.
        write_reg(CFG_START_MODE, (k % 3 == 0) ? 24'(k % 4) : 24'(MODE_STARTUP));
    endtask

    // Receiver: random stalls, with long hold-offs on request.
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            if (hold_request > 0) begin
                m_ready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end
            g = ($urandom_range(3) == 0) ? gap_len() : 0;
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Watchdog on cycles without any accepted transaction.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("bbr_congestion_mode_control_top: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int n;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings: repeated rounds, io events,
        // zero estimates that fall back to the defaults, field extremes.
        send_event(1'b0, 32'hFFFFFFFF, 24'd100, 24'd100, 32'd0, 1'b0);
        send_event(1'b0, 32'd0, 24'd0, 24'd0, 32'hFFFFFFFF, 1'b1);
        send_event(1'b0, 32'd0, 24'd5, 24'd5, 32'd0, 1'b0);
        send_event(1'b0, 32'd1, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0);
        send_event(1'b1, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1);
        send_event(1'b1, 32'd0, 24'd0, 24'd0, 32'd0, 1'b0);
        drain_results();
        // Probe rtt as a start mode, then startup through drain to probe bw.
        write_reg(CFG_START_MODE, 24'(MODE_PROBE_RTT));
        send_event(1'b0, 32'd7, 24'd1000, 24'd2000, 32'd3, 1'b0);
        drain_results();
        write_reg(CFG_START_MODE, 24'(MODE_STARTUP));
        send_event(1'b0, 32'd10, 24'd1000, 24'd1000, 32'd0, 1'b0);
        send_event(1'b1, 32'd0, 24'd1000, 24'd0, 32'd0, 1'b0);
        for (int i = 0; i < 4; i++) begin
            send_event(1'b0, 32'(11 + i), 24'd1000, 24'd1000, 32'hFFFFFFFF, 1'b0);
            send_event(1'b1, 32'd0, 24'd999, 24'd0, 32'd0, 1'b0);
        end
        // Drain with inflight above the latched product, then below.
        send_event(1'b0, 32'd20, 24'd1000, 24'd1000, 32'hFFFFFFFF, 1'b0);
        send_event(1'b0, 32'd21, 24'd1000, 24'd1000, 32'd0, 1'b0);
        drain_results();

        // Random part in phases, each with its own configuration.
        n = 0;
        for (int ph = 0; n < RANDOM_EVENTS; ph++) begin
            settle_config(ph);
            if (ph == 2) begin
                // The receiver holds off long while the sender keeps going.
                hold_request = 400;
            end
            for (int j = 0; j < 60 && n < RANDOM_EVENTS; j++) begin
                if ($urandom_range(9) == 0) begin
                    // Noise: a repeated round or a stray event.
                    send_event(1'($urandom), ($urandom_range(1) ? round_now : $urandom),
                               rand_field24(), rand_field24(), $urandom, 1'($urandom));
                    n++;
                end else begin
                    send_round(24'($urandom_range(1000, 5000)), ($urandom_range(2) != 0));
                    n += 2;
                end
            end
            // The sender pauses until everything has come back.
            drain_results();
        end

        drain_results();
        if (fail_count == 0)
            $display("bbr_congestion_mode_control_top: match");
        else
            $display("bbr_congestion_mode_control_top: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/bbr_pkg.sv
hdl/bbr_ctrl.sv
hdl/bbr_dp.sv
hdl/bbr_congestion_mode_control_top.sv
tb/bbr_congestion_mode_control_checker.sv
tb/tb_top.sv
